@@ hw/rtl/double_ended_queue_defines.svh @@
// assertion macros for the double-ended queue
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF

// expr holds at every clock edge out of reset
`define DEQ_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// when ante holds, cons holds in the following cycle
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define DEQ_ASSERT_ALWAYS(lbl, expr)
`define DEQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/deq_pkg.sv @@
// shared constants and types of the double-ended queue
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 8;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_REAR  = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // one access to the ring store
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  // result fields known at acceptance
  typedef struct packed {
    logic             rd_item;
    status_t          status;
    logic [CNT_W-1:0] occ;
  } resp_meta_t;

endpackage

@@ hw/rtl/deq_ram.sv @@
// single-port ring store with registered read data
module deq_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/deq_ctrl.sv @@
// head and count registers, command decode and store address generation
`include "double_ended_queue_defines.svh"

module deq_ctrl
  import deq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [DATA_W-1:0] push_value,
  output mem_req_t          req,
  output resp_meta_t        meta
);

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              empty, full;
  logic              is_pop;
  mem_req_t          req_raw;

  // slot that lies off places after the head, with wrap
  function automatic logic [ADDR_W-1:0] slot_at(input logic [ADDR_W-1:0] head,
                                                input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (ADDR_W+1)'(DEPTH)) begin
      sum = sum - (ADDR_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  assign empty  = (count_r == '0);
  assign full   = (count_r == CNT_W'(DEPTH));
  assign is_pop = (cmd_t'(cmd) == CMD_POP_FRONT) || (cmd_t'(cmd) == CMD_POP_REAR);

  always_comb begin
    head_nxt     = head_r;
    count_nxt    = count_r;
    req_raw      = '0;
    meta.rd_item = 1'b0;
    meta.status  = ST_OK;
    case (cmd_t'(cmd))
      CMD_PUSH_FRONT: begin
        if (full) begin
          meta.status = ST_FULL;
        end else begin
          head_nxt      = slot_at(head_r, ADDR_W'(DEPTH - 1));
          req_raw.we    = 1'b1;
          req_raw.addr  = head_nxt;
          req_raw.wdata = push_value;
          count_nxt     = count_r + 1'b1;
        end
      end
      CMD_PUSH_REAR: begin
        if (full) begin
          meta.status = ST_FULL;
        end else begin
          req_raw.we    = 1'b1;
          req_raw.addr  = slot_at(head_r, count_r[ADDR_W-1:0]);
          req_raw.wdata = push_value;
          count_nxt     = count_r + 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_PEEK_FRONT: begin
        if (empty) begin
          meta.status = ST_EMPTY;
        end else begin
          req_raw.re   = 1'b1;
          req_raw.addr = head_r;
          meta.rd_item = 1'b1;
          if (cmd_t'(cmd) == CMD_POP_FRONT) begin
            head_nxt  = slot_at(head_r, ADDR_W'(1));
            count_nxt = count_r - 1'b1;
          end
        end
      end
      CMD_POP_REAR, CMD_PEEK_REAR: begin
        if (empty) begin
          meta.status = ST_EMPTY;
        end else begin
          req_raw.re   = 1'b1;
          req_raw.addr = slot_at(head_r, ADDR_W'(count_r - 1'b1));
          meta.rd_item = 1'b1;
          if (cmd_t'(cmd) == CMD_POP_REAR) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      default: begin
        // unused codes leave the queue untouched
      end
    endcase
    meta.occ = count_nxt;
    req      = req_raw;
    if (!accept) begin
      req.we = 1'b0;
      req.re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  `DEQ_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(DEPTH))
  `DEQ_ASSERT_ALWAYS(a_head_bound, {1'b0, head_r} < (ADDR_W+1)'(DEPTH))
  `DEQ_ASSERT_NEXT(a_pop_shrinks, accept && !empty && is_pop, count_r == $past(count_r) - 1'b1)
  `DEQ_ASSERT_ALWAYS(a_one_access, !(req.we && req.re))

endmodule

@@ hw/rtl/double_ended_queue.sv @@
// top level of the double-ended queue
// Double-ended queue of byte items in a ring store of DEPTH entries (16 as
// built). Every input beat is one command (push or pop or peek, at front or
// rear) and yields exactly one output beat carrying the item, a status and
// the occupancy after the command. One command is taken per clock cycle
// while in_stall is low; its result appears the cycle after acceptance, from
// the registered read of the single-port store. Head index and item count
// live in registers and are updated at acceptance, so back-to-back commands
// need no interlock: a write lands in the store before any later read of it.
// The result register holds the beat while out_stall is high, and in that
// time in_stall is raised so no new command is taken. Pop or peek on an
// empty queue returns item 0 with status empty; a push into a full queue is
// dropped with status full; unused command codes return item 0, status ok.
`include "double_ended_queue_defines.svh"

module double_ended_queue
  import deq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // command beat
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [DATA_W-1:0] in_push_value,
  // result beat
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_item,
  output logic [STAT_W-1:0] out_status,
  output logic [OCC_W-1:0]  out_occupancy
);

  logic              accept;
  logic              res_valid_r, res_valid_nxt;
  resp_meta_t        res_meta_r;
  resp_meta_t        meta;
  mem_req_t          req;
  logic [DATA_W-1:0] rdata;

  // a waiting result blocks new commands only while the sink stalls
  assign in_stall = res_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .cmd        (in_command),
    .push_value (in_push_value),
    .req        (req),
    .meta       (meta)
  );

  // read data stays put until the next accepted read
  deq_ram #(
    .DATA_W (DATA_W),
    .DEPTH  (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .re    (req.re),
    .addr  (req.addr),
    .wdata (req.wdata),
    .rdata (rdata)
  );

  // result slot fills on accept, drains when taken
  assign res_valid_nxt = accept || (res_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  // result fields, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res_meta_r <= meta;
    end
  end

  assign out_valid     = res_valid_r;
  assign out_item      = res_meta_r.rd_item ? rdata : '0;
  assign out_status    = res_meta_r.status;
  assign out_occupancy = OCC_W'(res_meta_r.occ);

  `DEQ_ASSERT_NEXT(a_accept_shows, accept, res_valid_r)
  `DEQ_ASSERT_ALWAYS(a_empty_no_item, !(res_valid_r && res_meta_r.status == ST_EMPTY) || (out_item == '0))

endmodule
